>>> rtl/sdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdh_pkg;

  // Block geometry. The byte counter also counts dummy bytes, so it is at least 8 bits wide.
  localparam int BLOCK_BYTES = 512;
  localparam int BLK_W = $clog2(BLOCK_BYTES);
  localparam int CNT_W = (BLK_W > 8) ? BLK_W : 8;

  // Index of the last byte of a command frame.
  localparam int FRAME_LAST = 5;

  // Register file layout.
  localparam int REG_ADDR_W = 4;
  localparam logic [1:0] REG_DUMMY    = 2'd0;
  localparam logic [1:0] REG_ATTEMPTS = 2'd1;
  localparam logic [1:0] REG_POLLS    = 2'd2;

  localparam logic [7:0] RST_DUMMY    = 8'd10;
  localparam logic [7:0] RST_ATTEMPTS = 8'd100;
  localparam logic [7:0] RST_POLLS    = 8'd10;

  // Protocol bytes.
  localparam logic [7:0] BYTE_IDLE      = 8'hFF;
  localparam logic [7:0] TOKEN_START    = 8'hFE;
  localparam logic [7:0] CMD0           = 8'h40;
  localparam logic [7:0] CMD17          = 8'h40 | 8'd17;
  localparam logic [7:0] CMD24          = 8'h40 | 8'd24;
  localparam logic [7:0] CRC_CMD0       = 8'h95;
  localparam logic [7:0] CRC_DUMMY      = 8'hFF;
  localparam logic [7:0] R1_IDLE        = 8'h01;
  localparam logic [7:0] R1_READY       = 8'h00;
  localparam logic [7:0] DRESP_MASK     = 8'h1F;
  localparam logic [7:0] DRESP_ACCEPTED = 8'h05;

  // Request opcodes.
  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_XCHG  = 2'd3
  } op_t;

  // Completion status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CMD_ERR  = 2'd1;
  localparam logic [1:0] ST_DATA_ERR = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_DUMMY  = 4'd1,
    PH_FRAME  = 4'd2,
    PH_POLL   = 4'd3,
    PH_TOKEN  = 4'd4,
    PH_RDATA  = 4'd5,
    PH_RCRC   = 4'd6,
    PH_WTOKEN = 4'd7,
    PH_WDATA  = 4'd8,
    PH_WCRC   = 4'd9,
    PH_WRESP  = 4'd10,
    PH_BUSY   = 4'd11
  } phase_t;

  // Configuration registers as seen by the sequencer.
  typedef struct packed {
    logic [7:0] dummy_bytes;
    logic [7:0] attempts;
    logic [7:0] polls;
  } cfg_t;

  // Sequencer state carried from one request to the next.
  typedef struct packed {
    phase_t           phase;
    logic [1:0]       operation;
    logic [47:0]      frame;
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       poll_count;
    logic [7:0]       attempt_count;
  } seq_state_t;

  // One result.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       card_select;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       wr_take;
    logic       done_res;
    logic [1:0] status;
  } result_t;

  // A register written as zero behaves as one.
  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  // Byte i of a six-byte command frame, most significant first.
  function automatic logic [7:0] frame_byte(input logic [47:0] frame, input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = frame[47:40];
      3'd1:    b = frame[39:32];
      3'd2:    b = frame[31:24];
      3'd3:    b = frame[23:16];
      3'd4:    b = frame[15:8];
      default: b = frame[7:0];
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sdh_apb_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sdh_apb_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sdh_pkg::REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output sdh_pkg::cfg_t                       cfg
);
  import sdh_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dummy_bytes <= RST_DUMMY;
      cfg.attempts    <= RST_ATTEMPTS;
      cfg.polls       <= RST_POLLS;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DUMMY:    cfg.dummy_bytes <= pwdata[7:0];
        REG_ATTEMPTS: cfg.attempts    <= pwdata[7:0];
        REG_POLLS:    cfg.polls       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    unique case (reg_idx)
      REG_DUMMY:    prdata = {24'd0, cfg.dummy_bytes};
      REG_ATTEMPTS: prdata = {24'd0, cfg.attempts};
      REG_POLLS:    prdata = {24'd0, cfg.polls};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/sdh_step.sv
`timescale 1ns / 1ps
`default_nettype none

module sdh_step (
  input  wire sdh_pkg::seq_state_t st,
  input  wire sdh_pkg::cfg_t       cfg,
  input  wire logic [1:0]      op,
  input  wire logic [22:0]     sector,
  input  wire logic [7:0]      rx_byte,
  input  wire logic [7:0]      wr_data,
  output sdh_pkg::seq_state_t  st_next,
  output sdh_pkg::result_t     res
);
  import sdh_pkg::*;

  logic [7:0]   dummy_eff;
  logic [7:0]   attempts_eff;
  logic [7:0]   polls_eff;
  logic [CNT_W:0] cnt_inc;
  logic [8:0]   poll_inc;
  logic [7:0]   attempt_inc;
  logic [7:0]   cmd;

  assign dummy_eff    = at_least_one(cfg.dummy_bytes);
  assign attempts_eff = at_least_one(cfg.attempts);
  assign polls_eff    = at_least_one(cfg.polls);
  assign cnt_inc      = (CNT_W+1)'(st.byte_count) + (CNT_W+1)'(1);
  assign poll_inc     = {1'b0, st.poll_count} + 9'd1;
  assign attempt_inc  = st.attempt_count + 8'd1;
  assign cmd          = (op == OP_READ) ? CMD17 : CMD24;

  // Next state and result for one request.
  always_comb begin
    st_next = st;
    res     = '0;
    res.tx_byte = BYTE_IDLE;

    if (op != OP_XCHG) begin
      // A start request drops any running sequence.
      st_next.operation     = op;
      st_next.byte_count    = '0;
      st_next.poll_count    = '0;
      st_next.attempt_count = '0;
      res.tx_valid          = 1'b1;
      if (op == OP_INIT) begin
        st_next.frame = {CMD0, 32'd0, CRC_CMD0};
        st_next.phase = PH_DUMMY;
      end else begin
        st_next.frame    = {cmd, sector, 9'd0, CRC_DUMMY};
        st_next.phase    = PH_FRAME;
        res.tx_byte      = cmd;
        res.card_select  = 1'b1;
      end
    end else begin
      unique case (st.phase)
        PH_IDLE: ;
        PH_DUMMY: begin
          res.tx_valid = 1'b1;
          if (cnt_inc < (CNT_W+1)'(dummy_eff)) begin
            st_next.byte_count = cnt_inc[CNT_W-1:0];
          end else begin
            st_next.phase      = PH_FRAME;
            st_next.byte_count = '0;
            res.tx_byte        = frame_byte(st.frame, 3'd0);
            res.card_select    = 1'b1;
          end
        end
        PH_FRAME: begin
          res.tx_valid    = 1'b1;
          res.card_select = 1'b1;
          if (st.byte_count < CNT_W'(FRAME_LAST)) begin
            st_next.byte_count = cnt_inc[CNT_W-1:0];
            res.tx_byte        = frame_byte(st.frame, cnt_inc[2:0]);
          end else begin
            st_next.phase      = PH_POLL;
            st_next.poll_count = '0;
          end
        end
        PH_POLL: begin
          if (rx_byte[7] && (poll_inc < {1'b0, polls_eff})) begin
            // Still waiting for an R1 with the top bit clear.
            st_next.poll_count = poll_inc[7:0];
            res.tx_valid       = 1'b1;
            res.card_select    = 1'b1;
          end else if (st.operation == OP_INIT) begin
            if (rx_byte == R1_IDLE) begin
              st_next.phase = PH_IDLE;
              res.done_res  = 1'b1;
              res.status    = ST_OK;
            end else begin
              st_next.attempt_count = attempt_inc;
              if (attempt_inc >= attempts_eff) begin
                st_next.phase = PH_IDLE;
                res.done_res  = 1'b1;
                res.status    = ST_CMD_ERR;
              end else begin
                st_next.phase      = PH_FRAME;
                st_next.byte_count = '0;
                res.tx_byte        = frame_byte(st.frame, 3'd0);
                res.tx_valid       = 1'b1;
                res.card_select    = 1'b1;
              end
            end
          end else if (rx_byte != R1_READY) begin
            st_next.phase = PH_IDLE;
            res.done_res  = 1'b1;
            res.status    = ST_CMD_ERR;
          end else begin
            res.tx_valid    = 1'b1;
            res.card_select = 1'b1;
            if (st.operation == OP_READ) begin
              st_next.phase = PH_TOKEN;
            end else begin
              st_next.phase = PH_WTOKEN;
              res.tx_byte   = TOKEN_START;
            end
          end
        end
        PH_TOKEN: begin
          if (rx_byte == BYTE_IDLE) begin
            res.tx_valid    = 1'b1;
            res.card_select = 1'b1;
          end else if (rx_byte != TOKEN_START) begin
            st_next.phase = PH_IDLE;
            res.done_res  = 1'b1;
            res.status    = ST_DATA_ERR;
          end else begin
            st_next.phase      = PH_RDATA;
            st_next.byte_count = '0;
            res.tx_valid       = 1'b1;
            res.card_select    = 1'b1;
          end
        end
        PH_RDATA: begin
          res.rd_data     = rx_byte;
          res.rd_valid    = 1'b1;
          res.tx_valid    = 1'b1;
          res.card_select = 1'b1;
          if (st.byte_count != CNT_W'(BLOCK_BYTES - 1)) begin
            st_next.byte_count = cnt_inc[CNT_W-1:0];
          end else begin
            st_next.phase      = PH_RCRC;
            st_next.byte_count = '0;
          end
        end
        PH_RCRC: begin
          if (st.byte_count == '0) begin
            st_next.byte_count = CNT_W'(1);
            res.tx_valid       = 1'b1;
            res.card_select    = 1'b1;
          end else begin
            st_next.phase = PH_IDLE;
            res.done_res  = 1'b1;
            res.status    = ST_OK;
          end
        end
        PH_WTOKEN: begin
          st_next.phase      = PH_WDATA;
          st_next.byte_count = '0;
          res.wr_take        = 1'b1;
          res.tx_byte        = wr_data;
          res.tx_valid       = 1'b1;
          res.card_select    = 1'b1;
        end
        PH_WDATA: begin
          res.tx_valid    = 1'b1;
          res.card_select = 1'b1;
          if (st.byte_count != CNT_W'(BLOCK_BYTES - 1)) begin
            st_next.byte_count = cnt_inc[CNT_W-1:0];
            res.wr_take        = 1'b1;
            res.tx_byte        = wr_data;
          end else begin
            st_next.phase      = PH_WCRC;
            st_next.byte_count = '0;
          end
        end
        PH_WCRC: begin
          res.tx_valid    = 1'b1;
          res.card_select = 1'b1;
          if (st.byte_count == '0) begin
            st_next.byte_count = CNT_W'(1);
          end else begin
            st_next.phase = PH_WRESP;
          end
        end
        PH_WRESP: begin
          if ((rx_byte & DRESP_MASK) != DRESP_ACCEPTED) begin
            st_next.phase = PH_IDLE;
            res.done_res  = 1'b1;
            res.status    = ST_DATA_ERR;
          end else begin
            st_next.phase   = PH_BUSY;
            res.tx_valid    = 1'b1;
            res.card_select = 1'b1;
          end
        end
        PH_BUSY: begin
          // The card holds the line low while it programs the block.
          if (rx_byte == 8'd0) begin
            res.tx_valid    = 1'b1;
            res.card_select = 1'b1;
          end else begin
            st_next.phase = PH_IDLE;
            res.done_res  = 1'b1;
            res.status    = ST_OK;
          end
        end
        default: begin
          st_next.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/sd_spi_block_host.sv
// The result for a request is written into the output register when the request is accepted.
// Throughput: one request per cycle; the sequencer state and the result are both updated from
// one pass of the step logic. A result held by the receiver stalls requests, and a new request
// is taken in the same cycle the held result is accepted.
// Reset (synchronous, active high) returns the sequencer to idle with cleared counters, empties
// the output register and loads the register defaults 10, 100 and 10.
`timescale 1ns / 1ps
`default_nettype none

module sd_spi_block_host (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Request channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     op,
  input  wire logic [22:0]                    sector,
  input  wire logic [7:0]                     rx_byte,
  input  wire logic [7:0]                     wr_data,
  // Result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [7:0]                     tx_byte,
  output logic                                tx_valid,
  output logic                                card_select,
  output logic      [7:0]                     rd_data,
  output logic                                rd_valid,
  output logic                                wr_take,
  output logic                                done_res,
  output logic      [1:0]                     status,
  // Configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sdh_pkg::REG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);
  import sdh_pkg::*;

  cfg_t       cfg;
  seq_state_t st;
  seq_state_t st_next;
  result_t    res_next;
  result_t    res;
  logic       in_accept;

  sdh_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdh_step u_step (
    .st      (st),
    .cfg     (cfg),
    .op      (op),
    .sector  (sector),
    .rx_byte (rx_byte),
    .wr_data (wr_data),
    .st_next (st_next),
    .res     (res_next)
  );

  // A request is taken whenever the output register is free or being emptied.
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_IDLE;
      st.operation     <= '0;
      st.frame         <= '0;
      st.byte_count    <= '0;
      st.poll_count    <= '0;
      st.attempt_count <= '0;
    end else if (in_accept) begin
      st <= st_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res <= res_next;
    end
  end

  assign tx_byte     = res.tx_byte;
  assign tx_valid    = res.tx_valid;
  assign card_select = res.card_select;
  assign rd_data     = res.rd_data;
  assign rd_valid    = res.rd_valid;
  assign wr_take     = res.wr_take;
  assign done_res    = res.done_res;
  assign status      = res.status;

endmodule

`default_nettype wire
